// File: rtl/salu_pkg.sv
// Shared types, constants and codes for the stack-machine ALU.
// No dependencies; every other file of the block but salu_ram refers to it by scoped names.
package salu_pkg;

    localparam int WORD_W          = 32;
    localparam int OP_W            = 4;
    localparam int DEPTH_W         = 7;
    localparam int ERR_W           = 2;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int ITER_COUNT      = 32;
    localparam int CNT_W           = $clog2(ITER_COUNT);
    localparam int SHAMT_W         = 5;

    typedef enum logic [OP_W-1:0] {
        OP_CONST = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MOD   = 4'd5,
        OP_EQ    = 4'd6,
        OP_LT    = 4'd7,
        OP_GT    = 4'd8,
        OP_AND   = 4'd9,
        OP_OR    = 4'd10,
        OP_XOR   = 4'd11,
        OP_SHL   = 4'd12,
        OP_SHR   = 4'd13,
        OP_NOT   = 4'd14
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_DIVZ  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_EXEC,
        S_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        EX_IDLE,
        EX_MUL,
        EX_DIV
    } ex_state_t;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } ex_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } ex_rsp_t;

endpackage

// File: rtl/salu_ifs.sv
// Handshake channels of the stack-machine ALU: instruction word in, result word out.
// Depends on salu_pkg for the field widths.
interface salu_in_if;
    logic                          valid;
    logic                          ready;
    logic [salu_pkg::OP_W-1:0]     operation;
    logic [salu_pkg::WORD_W-1:0]   constant_value;

    modport source (output valid, output operation, output constant_value, input ready);
    modport sink (input valid, input operation, input constant_value, output ready);
endinterface

interface salu_out_if;
    logic                          valid;
    logic                          ready;
    logic [salu_pkg::WORD_W-1:0]   top_value;
    logic [salu_pkg::DEPTH_W-1:0]  stack_depth;
    logic [salu_pkg::ERR_W-1:0]    error_code;

    modport source (output valid, output top_value, output stack_depth, output error_code,
                    input ready);
    modport sink (input valid, input top_value, input stack_depth, input error_code,
                  output ready);
endinterface

// File: rtl/salu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module salu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/salu_exec.sv
// Shared arithmetic unit: one 33-bit adder serves add, sub, compares and the
// bit-serial multiply and restoring divide. Depends on salu_pkg.
module salu_exec (
    input  logic                          clk,
    input  logic                          rst_n,
    input  salu_pkg::ex_req_t             req,
    input  logic [salu_pkg::WORD_W-1:0]   a,
    input  logic [salu_pkg::WORD_W-1:0]   b,
    output salu_pkg::ex_rsp_t             rsp,
    output logic [salu_pkg::WORD_W-1:0]   result
);

    localparam int W = salu_pkg::WORD_W;

    salu_pkg::ex_state_t         st_reg, st_next;
    logic [W-1:0]                acc_reg, acc_next;
    logic [W-1:0]                opa_reg, opa_next;
    logic [W-1:0]                opb_reg, opb_next;
    logic [salu_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [salu_pkg::OP_W-1:0]   op_reg, op_next;
    logic [W-1:0]                res_reg, res_next;
    logic                        done_reg, done_next;
    logic                        divz_reg, divz_next;

    logic [W:0]                  add_x;
    logic [W:0]                  add_y;
    logic                        add_sub;
    logic [W+1:0]                add_sum;
    logic                        last_step;
    logic                        no_borrow;
    logic [W:0]                  div_shift;
    logic [W-1:0]                rem_step;
    logic [W-1:0]                quo_step;
    logic [salu_pkg::SHAMT_W-1:0] shamt;

    assign last_step = (cnt_reg == salu_pkg::CNT_W'(salu_pkg::ITER_COUNT - 1));
    assign shamt     = b[salu_pkg::SHAMT_W-1:0];
    assign div_shift = {acc_reg, opa_reg[W-1]};

    always_comb
    begin
        add_x   = {1'b0, a};
        add_y   = {1'b0, b};
        add_sub = 1'b0;
        unique case (st_reg)
            salu_pkg::EX_MUL:
            begin
                add_x = {1'b0, acc_reg};
                add_y = opb_reg[0] ? {1'b0, opa_reg} : '0;
            end
            salu_pkg::EX_DIV:
            begin
                add_x   = div_shift;
                add_y   = {1'b0, opb_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                if (req.op == salu_pkg::OP_GT)
                begin
                    add_x = {1'b0, b};
                    add_y = {1'b0, a};
                end
                add_sub = (req.op != salu_pkg::OP_ADD);
            end
        endcase
    end

    assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (W+2)'(add_sub);
    assign no_borrow = add_sum[W+1];
    assign rem_step  = no_borrow ? add_sum[W-1:0] : div_shift[W-1:0];
    assign quo_step  = {opa_reg[W-2:0], no_borrow};

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            salu_pkg::EX_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == salu_pkg::OP_MUL)
                    begin
                        st_next = salu_pkg::EX_MUL;
                    end
                    else if ((req.op == salu_pkg::OP_DIV || req.op == salu_pkg::OP_MOD)
                             && b != '0)
                    begin
                        st_next = salu_pkg::EX_DIV;
                    end
                end
            end
            salu_pkg::EX_MUL, salu_pkg::EX_DIV:
            begin
                if (last_step)
                begin
                    st_next = salu_pkg::EX_IDLE;
                end
            end
            default:
            begin
                st_next = salu_pkg::EX_IDLE;
            end
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        divz_next = divz_reg;
        unique case (st_reg)
            salu_pkg::EX_IDLE:
            begin
                if (req.start)
                begin
                    op_next   = req.op;
                    divz_next = 1'b0;
                    cnt_next  = '0;
                    done_next = 1'b1;
                    case (req.op)
                        salu_pkg::OP_ADD, salu_pkg::OP_SUB:
                        begin
                            res_next = add_sum[W-1:0];
                        end
                        salu_pkg::OP_EQ:
                        begin
                            res_next = W'(add_sum[W-1:0] == '0);
                        end
                        salu_pkg::OP_LT, salu_pkg::OP_GT:
                        begin
                            res_next = W'(!no_borrow);
                        end
                        salu_pkg::OP_AND:
                        begin
                            res_next = a & b;
                        end
                        salu_pkg::OP_OR:
                        begin
                            res_next = a | b;
                        end
                        salu_pkg::OP_XOR:
                        begin
                            res_next = a ^ b;
                        end
                        salu_pkg::OP_SHL:
                        begin
                            res_next = a << shamt;
                        end
                        salu_pkg::OP_SHR:
                        begin
                            res_next = a >> shamt;
                        end
                        salu_pkg::OP_MUL:
                        begin
                            done_next = 1'b0;
                            acc_next  = '0;
                            opa_next  = a;
                            opb_next  = b;
                        end
                        salu_pkg::OP_DIV, salu_pkg::OP_MOD:
                        begin
                            if (b == '0)
                            begin
                                divz_next = 1'b1;
                                res_next  = (req.op == salu_pkg::OP_DIV) ? '1 : a;
                            end
                            else
                            begin
                                done_next = 1'b0;
                                acc_next  = '0;
                                opa_next  = a;
                                opb_next  = b;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            salu_pkg::EX_MUL:
            begin
                acc_next = add_sum[W-1:0];
                opa_next = {opa_reg[W-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    res_next  = add_sum[W-1:0];
                    done_next = 1'b1;
                end
            end
            salu_pkg::EX_DIV:
            begin
                acc_next = rem_step;
                opa_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    res_next  = (op_reg == salu_pkg::OP_DIV) ? quo_step : rem_step;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= salu_pkg::EX_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            divz_reg <= 1'b0;
            op_reg   <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            divz_reg <= divz_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        res_reg <= res_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.div_zero = divz_reg;
    assign result       = res_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> st_reg == salu_pkg::EX_IDLE)
        else $error("exec start while busy");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == salu_pkg::EX_MUL || st_reg == salu_pkg::EX_DIV) && last_step |=> done_reg)
        else $error("iteration end without done");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");
`endif

endmodule

// File: rtl/stack_u32_alu_unit.sv
// Top level of the stack-machine ALU: sequencer, top-of-stack register, stack RAM
// and output register. Depends on salu_pkg, salu_ifs, salu_ram and salu_exec.
//
// Executes one stack instruction per accepted instruction word and returns one
// result word (new top, depth, error code) for each. The top of the stack lives
// in a register and the words below it in a RAM with registered read. const, not,
// the no-op code and any underflow or overflow need no RAM read; add, sub,
// compares, logic and shifts read the operand below the top from the RAM and then
// take their result straight from the shared unit, and so do div and mod by zero;
// mul, div and mod otherwise also run the shared adder through 32 shift-add or
// restoring-divide steps. A pending result in the output register does not stop a
// new instruction word from being accepted; the sequencer waits only if a second
// result is ready before the first one is taken.
module stack_u32_alu_unit #(
    parameter int STACK_DEPTH = salu_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    salu_in_if.sink    instr,
    salu_out_if.source result
);

    localparam int W    = salu_pkg::WORD_W;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);

    salu_pkg::seq_state_t         st_reg, st_next;
    logic [salu_pkg::OP_W-1:0]    op_reg, op_next;
    logic [W-1:0]                 cval_reg, cval_next;
    logic [W-1:0]                 tos_reg, tos_next;
    logic [SP_W-1:0]              sp_reg, sp_next;
    salu_pkg::err_t               err_reg, err_next;
    logic                         out_valid_reg, out_valid_next;
    logic [W-1:0]                 out_top_reg, out_top_next;
    logic [salu_pkg::DEPTH_W-1:0] out_depth_reg, out_depth_next;
    logic [salu_pkg::ERR_W-1:0]   out_err_reg, out_err_next;

    logic                         accept;
    logic                         slot_free;
    logic [SP_W-1:0]              sp_m1;
    logic [SP_W-1:0]              sp_m2;
    logic [SP_W+6:0]              depth_wide;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [W-1:0]                 ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [W-1:0]                 ram_rdata;

    salu_pkg::ex_req_t            ex_req;
    salu_pkg::ex_rsp_t            ex_rsp;
    logic [W-1:0]                 ex_result;

    assign accept     = instr.valid && instr.ready;
    assign slot_free  = !out_valid_reg || result.ready;
    assign sp_m1      = sp_reg - SP_W'(1);
    assign sp_m2      = sp_reg - SP_W'(2);
    assign depth_wide = (SP_W + 7)'(sp_reg);

    salu_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    salu_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ex_req),
        .a      (ram_rdata),
        .b      (tos_reg),
        .rsp    (ex_rsp),
        .result (ex_result)
    );

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            salu_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    st_next = salu_pkg::S_DECODE;
                end
            end
            salu_pkg::S_DECODE:
            begin
                if (op_reg >= salu_pkg::OP_ADD && op_reg <= salu_pkg::OP_SHR
                    && sp_reg >= SP_W'(2))
                begin
                    st_next = salu_pkg::S_READ;
                end
                else
                begin
                    st_next = salu_pkg::S_DONE;
                end
            end
            salu_pkg::S_READ:
            begin
                st_next = salu_pkg::S_EXEC;
            end
            salu_pkg::S_EXEC:
            begin
                if (ex_rsp.done)
                begin
                    st_next = salu_pkg::S_DONE;
                end
            end
            salu_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    st_next = salu_pkg::S_IDLE;
                end
            end
            default:
            begin
                st_next = salu_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        cval_next      = cval_reg;
        tos_next       = tos_reg;
        sp_next        = sp_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_top_next   = out_top_reg;
        out_depth_next = out_depth_reg;
        out_err_next   = out_err_reg;
        ram_we         = 1'b0;
        ram_waddr      = sp_m1[AW-1:0];
        ram_wdata      = tos_reg;
        ram_re         = 1'b0;
        ram_raddr      = sp_m2[AW-1:0];
        ex_req.start   = 1'b0;
        ex_req.op      = op_reg;
        unique case (st_reg)
            salu_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = instr.operation;
                    cval_next = instr.constant_value;
                    err_next  = salu_pkg::ERR_OK;
                end
            end
            salu_pkg::S_DECODE:
            begin
                unique case (op_reg) inside
                    salu_pkg::OP_CONST:
                    begin
                        if (sp_reg == SP_W'(STACK_DEPTH))
                        begin
                            err_next = salu_pkg::ERR_OVER;
                        end
                        else
                        begin
                            ram_we   = (sp_reg != '0);
                            tos_next = cval_reg;
                            sp_next  = sp_reg + SP_W'(1);
                        end
                    end
                    salu_pkg::OP_NOT:
                    begin
                        if (sp_reg == '0)
                        begin
                            err_next = salu_pkg::ERR_UNDER;
                        end
                        else
                        begin
                            tos_next = ~tos_reg;
                        end
                    end
                    [salu_pkg::OP_ADD:salu_pkg::OP_SHR]:
                    begin
                        if (sp_reg < SP_W'(2))
                        begin
                            err_next = salu_pkg::ERR_UNDER;
                        end
                        else
                        begin
                            ram_re = 1'b1;
                        end
                    end
                    default:
                    begin
                        err_next = salu_pkg::ERR_OK;
                    end
                endcase
            end
            salu_pkg::S_READ:
            begin
                ex_req.start = 1'b1;
            end
            salu_pkg::S_EXEC:
            begin
                if (ex_rsp.done)
                begin
                    tos_next = ex_result;
                    sp_next  = sp_m1;
                    err_next = ex_rsp.div_zero ? salu_pkg::ERR_DIVZ : salu_pkg::ERR_OK;
                end
            end
            salu_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_top_next   = (sp_reg != '0) ? tos_reg : '0;
                    out_depth_next = depth_wide[salu_pkg::DEPTH_W-1:0];
                    out_err_next   = err_reg;
                end
            end
            default:
            begin
                ex_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= salu_pkg::S_IDLE;
            op_reg        <= '0;
            sp_reg        <= '0;
            err_reg       <= salu_pkg::ERR_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            op_reg        <= op_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cval_reg      <= cval_next;
        tos_reg       <= tos_next;
        out_top_reg   <= out_top_next;
        out_depth_reg <= out_depth_next;
        out_err_reg   <= out_err_next;
    end

    assign instr.ready        = (st_reg == salu_pkg::S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.top_value   = out_top_reg;
    assign result.stack_depth = out_depth_reg;
    assign result.error_code  = out_err_reg;

`ifndef SYNTH
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(st_reg) == salu_pkg::S_DONE)
        else $error("result word loaded outside of completion");

    a_done_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ex_rsp.done |-> st_reg == salu_pkg::S_EXEC)
        else $error("exec unit finished while sequencer not waiting");
`endif

endmodule

// File: bench/stack_u32_alu_unit_tb.sv
// Testbench for stack_u32_alu_unit: drives instruction words, predicts every result
// word from its own stack copy and checks them in order. Depends on salu_pkg, salu_ifs.
module stack_u32_alu_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W = salu_pkg::WORD_W;
    localparam int OP_W = salu_pkg::OP_W;
    localparam int DEPTH_W = salu_pkg::DEPTH_W;
    localparam int SHAMT_W = salu_pkg::SHAMT_W;
    localparam int STACK_WORDS = salu_pkg::STACK_DEPTH_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 4'hF;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 60;
    localparam int PRINT_CAP = 40;

    typedef struct {
        logic [WORD_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        salu_pkg::err_t     err;
    } alu_result_t;

    logic clk = 1'b0;
    logic rst_n;

    salu_in_if  instr_if ();
    salu_out_if result_if ();

    stack_u32_alu_unit #(
        .STACK_DEPTH(STACK_WORDS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_if),
        .result (result_if)
    );

    logic [WORD_W-1:0] model_stack [STACK_WORDS];
    int unsigned       model_sp = 0;
    alu_result_t       expected_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq = 0;
    int hold_ack = 0;
    int hold_left = 0;

    int error_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int underflow_count = 0;
    int overflow_count = 0;
    int divzero_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #15_000_000;
        $display("TIMEOUT: %0d words sent, %0d results checked, %0d pending",
                 words_sent, results_checked, expected_results.size());
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (error_count < PRINT_CAP)
            $display("MISMATCH %s: got %h, expected %h (result %0d)",
                     field, got, want, results_checked);
        error_count++;
    endtask

    function automatic alu_result_t predict_step(input logic [OP_W-1:0] op,
                                                 input logic [WORD_W-1:0] value);
        alu_result_t       res;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] r;
        salu_pkg::err_t    err;
        err = salu_pkg::ERR_OK;
        if (op == salu_pkg::OP_CONST)
        begin
            if (model_sp >= STACK_WORDS)
                err = salu_pkg::ERR_OVER;
            else
            begin
                model_stack[model_sp] = value;
                model_sp++;
            end
        end
        else if (op == salu_pkg::OP_NOT)
        begin
            if (model_sp < 1)
                err = salu_pkg::ERR_UNDER;
            else
                model_stack[model_sp-1] = ~model_stack[model_sp-1];
        end
        else if (op != OP_UNUSED)
        begin
            if (model_sp < 2)
                err = salu_pkg::ERR_UNDER;
            else
            begin
                b = model_stack[model_sp-1];
                a = model_stack[model_sp-2];
                case (salu_pkg::op_t'(op))
                    salu_pkg::OP_ADD: r = a + b;
                    salu_pkg::OP_SUB: r = a - b;
                    salu_pkg::OP_MUL: r = a * b;
                    salu_pkg::OP_DIV:
                    begin
                        if (b == '0)
                        begin
                            r = '1;
                            err = salu_pkg::ERR_DIVZ;
                        end
                        else
                            r = a / b;
                    end
                    salu_pkg::OP_MOD:
                    begin
                        if (b == '0)
                        begin
                            r = a;
                            err = salu_pkg::ERR_DIVZ;
                        end
                        else
                            r = a % b;
                    end
                    salu_pkg::OP_EQ:  r = (a == b) ? 32'd1 : 32'd0;
                    salu_pkg::OP_LT:  r = (a < b) ? 32'd1 : 32'd0;
                    salu_pkg::OP_GT:  r = (a > b) ? 32'd1 : 32'd0;
                    salu_pkg::OP_AND: r = a & b;
                    salu_pkg::OP_OR:  r = a | b;
                    salu_pkg::OP_XOR: r = a ^ b;
                    salu_pkg::OP_SHL: r = a << b[SHAMT_W-1:0];
                    default: r = a >> b[SHAMT_W-1:0];
                endcase
                model_stack[model_sp-2] = r;
                model_sp--;
            end
        end
        case (err)
            salu_pkg::ERR_UNDER: underflow_count++;
            salu_pkg::ERR_OVER:  overflow_count++;
            salu_pkg::ERR_DIVZ:  divzero_count++;
            default: ;
        endcase
        res.top = (model_sp > 0) ? model_stack[model_sp-1] : '0;
        res.depth = DEPTH_W'(model_sp);
        res.err = err;
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return 32'h8000_0000;
            4: return WORD_W'($urandom_range(40));
            5: return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_binary_op();
        return OP_W'($urandom_range(salu_pkg::OP_SHR, salu_pkg::OP_ADD));
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value);
        expected_results.push_back(predict_step(op, value));
        if ($urandom_range(99) < send_idle_pct)
        begin
            instr_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        instr_if.valid          <= 1'b1;
        instr_if.operation      <= op;
        instr_if.constant_value <= value;
        do
            @(posedge clk);
        while (!instr_if.ready);
        words_sent++;
    endtask

    task automatic finish_phase();
        instr_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic test_directed();
        logic [WORD_W-1:0] operands [13] = '{32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd1,
                                             32'd0, 32'd2, 32'd0, 32'hFFFF_FFFF,
                                             32'h8000_0000, 32'hFFFF_FFFF, 32'd33, 32'd31};
        int k;
        send_word(OP_UNUSED, 32'hFFFF_FFFF);
        send_word(salu_pkg::OP_ADD, 32'h0);
        send_word(salu_pkg::OP_NOT, 32'h0);
        send_word(salu_pkg::OP_CONST, 32'hFFFF_FFFF);
        send_word(salu_pkg::OP_SHR, 32'h5A5A_5A5A);
        send_word(salu_pkg::OP_NOT, 32'h0);
        send_word(salu_pkg::OP_CONST, 32'h0);
        send_word(salu_pkg::OP_DIV, 32'h0);
        send_word(salu_pkg::OP_CONST, 32'h0);
        send_word(salu_pkg::OP_MOD, 32'h0);
        for (k = salu_pkg::OP_ADD; k <= salu_pkg::OP_SHR; k++)
        begin
            send_word(salu_pkg::OP_CONST, operands[k-salu_pkg::OP_ADD]);
            send_word(salu_pkg::op_t'(k), $urandom);
        end
        finish_phase();
    endtask

    task automatic test_full_stack();
        while (model_sp < STACK_WORDS)
            send_word(salu_pkg::OP_CONST, pick_word());
        repeat (2)
            send_word(salu_pkg::OP_CONST, $urandom);
        send_word(salu_pkg::OP_NOT, $urandom);
        while (model_sp > 1)
            send_word(pick_binary_op(), $urandom);
        finish_phase();
    endtask

    task automatic test_random_stream(input int count);
        int sent;
        int burst_left;
        int r;
        sent = 0;
        burst_left = 0;
        while (sent < count)
        begin
            r = $urandom_range(99);
            if (burst_left > 0)
            begin
                send_word(salu_pkg::OP_CONST, pick_word());
                burst_left--;
                sent++;
            end
            else if (r < 2)
                burst_left = STACK_WORDS - model_sp + $urandom_range(2, 1);
            else
            begin
                if (r < 6)
                    send_word(OP_W'($urandom_range(OP_UNUSED, salu_pkg::OP_CONST)),
                              $urandom);
                else if (model_sp < 2)
                    send_word(salu_pkg::OP_CONST, pick_word());
                else if (model_sp >= STACK_WORDS)
                    send_word(pick_binary_op(), $urandom);
                else if (r < 45)
                    send_word(salu_pkg::OP_CONST, pick_word());
                else if (r < 50)
                    send_word(salu_pkg::OP_NOT, $urandom);
                else
                    send_word(pick_binary_op(), $urandom);
                sent++;
            end
        end
        finish_phase();
    endtask

    task automatic test_output_stall();
        hold_seq++;
        test_random_stream(40);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_if.ready <= 1'b0;
        end
        else if (hold_seq != hold_ack)
        begin
            hold_ack <= hold_seq;
            hold_left <= HOLD_CYCLES;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        alu_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result_if.top_value, '0);
            else
            begin
                want = expected_results.pop_front();
                if (result_if.top_value !== want.top)
                    report_mismatch("top_value", result_if.top_value, want.top);
                if (result_if.stack_depth !== want.depth)
                    report_mismatch("stack_depth", WORD_W'(result_if.stack_depth),
                                    WORD_W'(want.depth));
                if (result_if.error_code !== want.err)
                    report_mismatch("error_code", WORD_W'(result_if.error_code),
                                    WORD_W'(want.err));
            end
            results_checked++;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        instr_if.valid = 1'b0;
        instr_if.operation = salu_pkg::OP_CONST;
        instr_if.constant_value = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(33, 79);
        test_directed();
        test_full_stack();
        test_random_stream(700);

        set_idling(79, 33);
        test_output_stall();
        test_random_stream(700);

        set_idling(0, 0);
        test_random_stream(600);

        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Ran %0d instruction words, checked %0d result words, %0d mismatches",
                 words_sent, results_checked, error_count);
        $display("Hit %0d underflows, %0d overflows, %0d divides by zero",
                 underflow_count, overflow_count, divzero_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: sim.f
rtl/salu_pkg.sv
rtl/salu_ifs.sv
rtl/salu_ram.sv
rtl/salu_exec.sv
rtl/stack_u32_alu_unit.sv
bench/stack_u32_alu_unit_tb.sv
